// ----- rtl/vrc4_pkg.sv -----
// Package: beat types, decode constants and IRQ command struct for the VRC4 mapper.
`default_nettype none

package vrc4_pkg;

    // Input and result beats
    typedef struct packed {
        logic        func;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  cycles;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0] update_kind;
        logic [2:0] slot;
        logic [7:0] bank;
        logic       irq_line;
    } res_beat_t;

    // Beat function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Update kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_PRG    = 2'd1;
    localparam logic [1:0] KIND_CHR    = 2'd2;
    localparam logic [1:0] KIND_MIRROR = 2'd3;

    // Address decode
    localparam logic [15:0] DECODE_MASK  = 16'hF0CF;
    localparam logic [15:0] ADDR_PRG0    = 16'h8000;
    localparam logic [15:0] ADDR_PRG1    = 16'hA000;
    localparam logic [15:0] ADDR_MIRROR  = 16'h9000;
    localparam logic [15:0] ADDR_SWAP_A  = 16'h9002;
    localparam logic [15:0] ADDR_SWAP_B  = 16'h9080;
    localparam logic [3:0]  HI_CHR_FIRST = 4'hB;
    localparam logic [3:0]  HI_CHR_LAST  = 4'hE;
    localparam logic [3:0]  HI_IRQ       = 4'hF;

    // PRG slots
    localparam logic [2:0] SLOT_PRG_LO  = 3'd4;
    localparam logic [2:0] SLOT_PRG_MID = 3'd5;
    localparam logic [2:0] SLOT_PRG_HI  = 3'd6;

    // IRQ prescaler
    localparam logic signed [10:0] PRESCALE_ADD = 11'sd114;
    localparam logic signed [10:0] PRESCALE_MIN = -11'sd512;
    localparam logic [7:0]         COUNT_TOP    = 8'hFF;

    // Commands from the decoder to the IRQ counter
    typedef struct packed {
        logic       reload_lo_wr;
        logic       reload_hi_wr;
        logic       ack;
        logic       enable_wr;
        logic       tick;
        logic [7:0] data;
        logic [7:0] cycles;
    } irq_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/vrc4_decode.sv -----
// Write decode, CHR bank registers and swap mode for the VRC4 mapper.
`default_nettype none

module vrc4_decode (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire vrc4_pkg::cmd_beat_t beat,
    output vrc4_pkg::res_beat_t     res,
    output vrc4_pkg::irq_cmd_t      irq_cmd
);

    logic [7:0]  chr_reg [8];
    logic [7:0]  chr_next [8];
    logic        swap_reg;
    logic        swap_next;

    logic [15:0] addr_m;
    logic [3:0]  hi;
    logic [7:0]  low;
    logic [3:0]  hi_off;
    logic        sub_ok;
    logic [1:0]  sub;
    logic [2:0]  chr_idx;
    logic [7:0]  chr_val;

    assign addr_m  = beat.address & vrc4_pkg::DECODE_MASK;
    assign hi      = addr_m[15:12];
    assign low     = addr_m[7:0];
    assign hi_off  = hi - vrc4_pkg::HI_CHR_FIRST;
    assign chr_idx = {hi_off[1:0], sub[1]};
    assign chr_val = sub[0] ? {beat.data[3:0], chr_reg[chr_idx][3:0]}
                            : {chr_reg[chr_idx][7:4], beat.data[3:0]};

    // CHR register pair sub-select: bit 1 picks odd register, bit 0 high nibble
    always_comb
    begin
        sub_ok = 1'b1;
        sub    = 2'd0;
        case (low)
            8'h00: sub = 2'd0;
            8'h02, 8'h40: sub = 2'd1;
            8'h01, 8'h04, 8'h80: sub = 2'd2;
            8'h03, 8'h06, 8'hC0: sub = 2'd3;
            default: sub_ok = 1'b0;
        endcase
    end

    // Register decode
    always_comb
    begin
        res       = '0;
        irq_cmd   = '0;
        swap_next = swap_reg;
        for (int i = 0; i < 8; i++)
        begin
            chr_next[i] = chr_reg[i];
        end
        irq_cmd.data   = beat.data;
        irq_cmd.cycles = beat.cycles;

        if (beat.func == vrc4_pkg::FUNC_WRITE)
        begin
            if (addr_m == vrc4_pkg::ADDR_PRG0)
            begin
                res.update_kind = vrc4_pkg::KIND_PRG;
                res.slot        = swap_reg ? vrc4_pkg::SLOT_PRG_HI : vrc4_pkg::SLOT_PRG_LO;
                res.bank        = beat.data;
            end
            else if (addr_m == vrc4_pkg::ADDR_PRG1)
            begin
                res.update_kind = vrc4_pkg::KIND_PRG;
                res.slot        = vrc4_pkg::SLOT_PRG_MID;
                res.bank        = beat.data;
            end
            else if (addr_m == vrc4_pkg::ADDR_MIRROR)
            begin
                res.update_kind = vrc4_pkg::KIND_MIRROR;
                res.bank        = {6'd0, beat.data[1:0]};
            end
            else if (addr_m == vrc4_pkg::ADDR_SWAP_A || addr_m == vrc4_pkg::ADDR_SWAP_B)
            begin
                swap_next = beat.data[1];
            end
            else if (hi inside {[vrc4_pkg::HI_CHR_FIRST:vrc4_pkg::HI_CHR_LAST]})
            begin
                if (sub_ok)
                begin
                    chr_next[chr_idx] = chr_val;
                    res.update_kind   = vrc4_pkg::KIND_CHR;
                    res.slot          = chr_idx;
                    res.bank          = chr_val;
                end
            end
            else if (hi == vrc4_pkg::HI_IRQ)
            begin
                case (low)
                    8'h00: irq_cmd.reload_lo_wr = 1'b1;
                    8'h02, 8'h40: irq_cmd.reload_hi_wr = 1'b1;
                    8'h03, 8'h06, 8'hC0: irq_cmd.ack = 1'b1;
                    8'h04, 8'h80: irq_cmd.enable_wr = 1'b1;
                    default: ;
                endcase
            end
        end
        else
        begin
            irq_cmd.tick = 1'b1;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chr_reg[i] <= 8'(i);
            end
        end
        else if (fire)
        begin
            swap_reg <= swap_next;
            for (int i = 0; i < 8; i++)
            begin
                chr_reg[i] <= chr_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vrc4_irq.sv -----
// IRQ prescaler, up-counter, reload latch and interrupt line for the VRC4 mapper.
`default_nettype none

module vrc4_irq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire vrc4_pkg::irq_cmd_t cmd,
    output logic                    irq_line
);

    logic [1:0]        en_reg, en_next;
    logic [7:0]        count_reg, count_next;
    logic [7:0]        reload_reg, reload_next;
    logic [9:0]        pre_reg, pre_next;
    logic              out_reg, out_next;

    logic signed [10:0] diff;
    logic signed [10:0] adj;

    // Prescaler step: subtract, add once on underflow, then saturate
    assign diff = $signed({pre_reg[9], pre_reg}) - $signed({3'b000, cmd.cycles});
    assign adj  = diff[10] ? diff + vrc4_pkg::PRESCALE_ADD : diff;

    always_comb
    begin
        en_next     = en_reg;
        count_next  = count_reg;
        reload_next = reload_reg;
        pre_next    = pre_reg;
        out_next    = out_reg;

        if (cmd.reload_lo_wr)
        begin
            reload_next = {reload_reg[7:4], cmd.data[3:0]};
        end
        else if (cmd.reload_hi_wr)
        begin
            reload_next = {cmd.data[3:0], reload_reg[3:0]};
        end
        else if (cmd.ack)
        begin
            en_next  = {2{en_reg[0]}};
            pre_next = '0;
            out_next = 1'b0;
        end
        else if (cmd.enable_wr)
        begin
            en_next = cmd.data[1:0];
            if (cmd.data[1])
            begin
                count_next = reload_reg;
                pre_next   = '0;
            end
            out_next = 1'b0;
        end
        else if (cmd.tick && en_reg[1])
        begin
            if (diff[10])
            begin
                if (count_reg == vrc4_pkg::COUNT_TOP)
                begin
                    count_next = reload_reg;
                    out_next   = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 8'd1;
                end
            end
            if (adj < vrc4_pkg::PRESCALE_MIN)
            begin
                pre_next = vrc4_pkg::PRESCALE_MIN[9:0];
            end
            else
            begin
                pre_next = adj[9:0];
            end
        end
    end

    // Line level after this beat
    assign irq_line = out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg     <= '0;
            count_reg  <= '0;
            reload_reg <= '0;
            pre_reg    <= '0;
            out_reg    <= 1'b0;
        end
        else if (fire)
        begin
            en_reg     <= en_next;
            count_reg  <= count_next;
            reload_reg <= reload_next;
            pre_reg    <= pre_next;
            out_reg    <= out_next;
        end
    end

`ifndef SYNTHESIS
    // Prescaler stays within its reachable range
    assert property (@(posedge clk) disable iff (!rst_n)
        ($signed({pre_reg[9], pre_reg}) >= vrc4_pkg::PRESCALE_MIN) &&
        ($signed(pre_reg) <= 10'sd113))
        else $error("prescaler out of range");

    // Acknowledge drops the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd.ack) |=> !out_reg)
        else $error("irq line high after acknowledge");

    // A tick while disabled leaves the counter alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd.tick && !en_reg[1]) |=> (count_reg == $past(count_reg)))
        else $error("counter moved while disabled");
`endif

endmodule

`default_nettype wire

// ----- rtl/vrc4_bank_mapper_with_irq_core.sv -----
// Top level of the VRC4 bank mapper with IRQ counter: input and result registers.
//
//   channel | direction | handshake          | payload
//   cmd     | in        | cmd_valid/cmd_stall | cmd_beat_t: func, address, data, cycles
//   res     | out       | res_valid/res_stall | res_beat_t: update_kind, slot, bank, irq_line
//
// One beat per clock sustained while res is not stalled; an accepted beat sits
// in the input register, is decoded and registered in the result register,
// and res_valid rises with it.
// Reset is asynchronous: CHR bank i to i, control state to zero; data registers not reset.
// A stall on res holds the result register; cmd_stall rises in the same cycle
// when both registers are full and res is stalled.
`default_nettype none

module vrc4_bank_mapper_with_irq_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire vrc4_pkg::cmd_beat_t cmd,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output vrc4_pkg::res_beat_t     res
);

    logic                 in_valid_reg;
    vrc4_pkg::cmd_beat_t  in_beat_reg;
    vrc4_pkg::res_beat_t  res_reg, res_next;
    logic                 advance;
    logic                 fire;
    vrc4_pkg::res_beat_t  dec_res;
    vrc4_pkg::irq_cmd_t   irq_cmd;
    logic                 irq_line;

    // Pipeline control
    assign advance   = !res_valid || !res_stall;
    assign fire      = in_valid_reg && advance;
    assign cmd_stall = in_valid_reg && !advance;

    vrc4_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .beat    (in_beat_reg),
        .res     (dec_res),
        .irq_cmd (irq_cmd)
    );

    vrc4_irq u_irq (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .cmd      (irq_cmd),
        .irq_line (irq_line)
    );

    // Merge mapping update with IRQ level
    always_comb
    begin
        res_next          = dec_res;
        res_next.irq_line = irq_line;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            in_beat_reg <= cmd;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid <= 1'b0;
        end
        else if (advance)
        begin
            res_valid <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

`ifndef SYNTHESIS
    // Input side only stalls when both stages are full
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (in_valid_reg && res_valid))
        else $error("stall without full pipeline");

    // A processed beat lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid)
        else $error("processed beat lost");

    // Result taken with nothing behind it empties the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && !in_valid_reg) |=> !res_valid)
        else $error("result repeated");
`endif

endmodule

`default_nettype wire
